// ===== design/srs_pkg.sv =====
// Shared types and constants for the Siddon ray-sum unit.
// Used by srs_div, srs_mul, srs_mem and siddon_ray_sum_drr_unit; depends on nothing.
`timescale 1ns / 1ps
package srs_pkg;

  localparam int ALPHA_W    = 64;  // alpha, numerators, entry points
  localparam int COORD_W    = 32;  // Q16.16 coordinates
  localparam int SPC_W      = 24;  // Q8.16 spacing
  localparam int VOX_W      = 16;  // voxel and pixel values
  localparam int ADDR_W     = 18;  // volume memory address
  localparam int R_W        = COORD_W + 1;  // ray direction, signed
  localparam int DEN_W      = COORD_W;      // divisor: |ray| or spacing
  localparam int DIFF_W     = VOX_W;        // voxel excess over threshold, unsigned
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  localparam int IN_TDATA_W = 136;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  typedef enum logic [2:0] {
    REG_CAM_X = 3'd0,
    REG_CAM_Y = 3'd1,
    REG_CAM_Z = 3'd2,
    REG_SPC_X = 3'd3,
    REG_SPC_Y = 3'd4,
    REG_SPC_Z = 3'd5,
    REG_THR   = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RAY  = 1'b1
  } opcode_e;

  localparam logic signed [ALPHA_W-1:0] ALPHA_BIG = 64'sh4000_0000_0000_0000;
  localparam logic [SPC_W-1:0]          SPC_RESET = 24'h01_0000;
  localparam logic [VOX_W-1:0]          PIX_MAX   = 16'h7fff;

endpackage

// ===== design/siddon_ray_sum_drr_unit.sv =====
// Siddon ray-sum unit: a load word writes one voxel. A ray word first runs a setup of
// up to fifteen 64-bit divisions on one bit-serial divider and up to three multiplies,
// then walks the voxel segments through states WALK, END, DLT, MUL and ACC, at most
// DIM_X+DIM_Y+DIM_Z+3 segments, one volume memory read each. The divider sets
// the setup time. The input is not ready while a ray runs; the pixel is held in an
// output register. Volume memory has no clearing pass; read only voxels you loaded.
`timescale 1ns / 1ps
module siddon_ray_sum_drr_unit #(
  parameter int DIM_X     = 64,
  parameter int DIM_Y     = 64,
  parameter int DIM_Z     = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // voxel_address[17:0], voxel_value[33:18], point_x[65:34], point_y[97:66],
  // point_z[129:98], zero fill
  input  logic [srs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_value[15:0]
  output logic [srs_pkg::VOX_W-1:0]          m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srs_pkg::APB_AW-1:0]         paddr,
  input  logic [srs_pkg::APB_DW-1:0]         pwdata,
  output logic [srs_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int AW        = srs_pkg::ALPHA_W;
  localparam int MAX_STEPS = DIM_X + DIM_Y + DIM_Z + 3;
  localparam int DMAX      = (DIM_X > DIM_Y) ? ((DIM_X > DIM_Z) ? DIM_X : DIM_Z)
                                             : ((DIM_Y > DIM_Z) ? DIM_Y : DIM_Z);
  localparam int IDX_W     = $clog2(DMAX + MAX_STEPS + 2) + 1;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int ACC_W     = FRAC_BITS + 16;
  localparam int PROD_W    = ACC_W + srs_pkg::DIFF_W;
  localparam int PL_W      = IDX_W + 1 + srs_pkg::SPC_W + 1;
  localparam int SPAN_W    = 10 + srs_pkg::SPC_W;
  localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(1) << (ACC_W - 1);
  localparam logic signed [AW-1:0]    DIMS64 [3] = '{AW'(DIM_X), AW'(DIM_Y), AW'(DIM_Z)};
  localparam logic signed [IDX_W-1:0] DIMS_I [3] = '{IDX_W'(DIM_X), IDX_W'(DIM_Y),
                                                      IDX_W'(DIM_Z)};
  localparam logic [9:0]              DIMS_U [3] = '{10'(DIM_X), 10'(DIM_Y), 10'(DIM_Z)};

  typedef enum logic [4:0] {
    ST_IDLE, ST_BND0, ST_BND1, ST_BNDUP, ST_CHECK, ST_ENT, ST_MWAIT, ST_EDIV, ST_IDX,
    ST_PL, ST_NXT, ST_DU, ST_DUWR, ST_DWAIT, ST_WALK, ST_END, ST_DLT, ST_MUL, ST_ACC,
    ST_FIN
  } state_e;

  // ---------------- configuration registers ----------------
  logic signed [srs_pkg::COORD_W-1:0] cam_q [3];
  logic        [srs_pkg::SPC_W-1:0]   spc_q [3];
  logic signed [srs_pkg::VOX_W-1:0]   thr_q;
  logic                               cfg_wr;
  srs_pkg::cfg_reg_e                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = srs_pkg::cfg_reg_e'(paddr[srs_pkg::APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cam_q[i] <= '0;
        spc_q[i] <= srs_pkg::SPC_RESET;
      end
      thr_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srs_pkg::REG_CAM_X: cam_q[0] <= pwdata;
        srs_pkg::REG_CAM_Y: cam_q[1] <= pwdata;
        srs_pkg::REG_CAM_Z: cam_q[2] <= pwdata;
        srs_pkg::REG_SPC_X: spc_q[0] <= pwdata[srs_pkg::SPC_W-1:0];
        srs_pkg::REG_SPC_Y: spc_q[1] <= pwdata[srs_pkg::SPC_W-1:0];
        srs_pkg::REG_SPC_Z: spc_q[2] <= pwdata[srs_pkg::SPC_W-1:0];
        srs_pkg::REG_THR:   thr_q    <= pwdata[srs_pkg::VOX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      srs_pkg::REG_CAM_X: prdata = cam_q[0];
      srs_pkg::REG_CAM_Y: prdata = cam_q[1];
      srs_pkg::REG_CAM_Z: prdata = cam_q[2];
      srs_pkg::REG_SPC_X: prdata = {8'd0, spc_q[0]};
      srs_pkg::REG_SPC_Y: prdata = {8'd0, spc_q[1]};
      srs_pkg::REG_SPC_Z: prdata = {8'd0, spc_q[2]};
      srs_pkg::REG_THR:   prdata = 32'(thr_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  state_e                       state_q, ret_q;
  logic [1:0]                   k_q;
  logic signed [srs_pkg::R_W-1:0] r_q [3];
  logic signed [AW-1:0]         amin_q, amax_q, a0_q, ac_q, end_q, nmin_q, delta_q;
  logic signed [AW-1:0]         nxt_q [3];
  logic signed [AW-1:0]         du_q [3];
  logic signed [IDX_W-1:0]      idx_q [3];
  logic signed [PL_W-1:0]       pl_q;
  logic                         any_q, inb_q, use_q, big_q;
  logic [1:0]                   sel_q;
  logic [srs_pkg::DIFF_W-1:0]   d_q;
  logic [PROD_W-1:0]            prod_q;
  logic [ACC_W-1:0]             acc_q;
  logic [STEP_W-1:0]            step_q;
  logic                         mvalid_q;
  logic [srs_pkg::VOX_W-1:0]    mdata_q;

  // ---------------- shared units ----------------
  logic                         div_start, div_done, mul_start, mul_done;
  logic signed [AW-1:0]         div_num, div_quo, mul_p;
  logic [srs_pkg::DEN_W-1:0]    div_den;
  logic                         in_acc, mem_we, mem_re;
  logic [srs_pkg::VOX_W-1:0]    mem_rdata;
  logic [31:0]                  addr_w;

  srs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  srs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (amin_q),
    .b_i     (r_q[k_q]),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  srs_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s_axis_tdata[srs_pkg::ADDR_W-1:0]),
    .wdata_i (s_axis_tdata[srs_pkg::ADDR_W +: srs_pkg::VOX_W]),
    .re_i    (mem_re),
    .raddr_i (addr_w[srs_pkg::ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign mem_we        = in_acc & (s_axis_tuser == srs_pkg::OP_LOAD);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  // ---------------- per-axis operands ----------------
  logic signed [srs_pkg::R_W-1:0]  r_k, r_abs;
  logic                            r_neg;
  logic [srs_pkg::DEN_W-1:0]       ar_k;
  logic [srs_pkg::SPC_W-1:0]       sp_k;
  logic [SPAN_W-1:0]               span_k;
  logic signed [AW-1:0]            cam64, sp64, n0, n1, e_pos, n_nxt, q_raw, q_clamp;
  logic signed [IDX_W:0]           idx_up;

  always_comb begin
    r_k    = r_q[k_q];
    r_neg  = r_k[srs_pkg::R_W-1];
    r_abs  = r_neg ? (-r_k) : r_k;
    ar_k   = r_abs[srs_pkg::DEN_W-1:0];
    sp_k   = (spc_q[k_q] == '0) ? srs_pkg::SPC_W'(1) : spc_q[k_q];
    cam64  = AW'(cam_q[k_q]);
    sp64   = $signed({{(AW - srs_pkg::SPC_W){1'b0}}, sp_k});
    // box extent along this axis: small dimension times spacing
    span_k = DIMS_U[k_q] * sp_k;
    n0     = (64'sd0 - cam64) <<< FRAC_BITS;
    n1     = ($signed({{(AW - SPAN_W){1'b0}}, span_k}) - cam64) <<< FRAC_BITS;
    e_pos  = cam64 + (mul_p >>> FRAC_BITS);
    n_nxt  = (AW'(pl_q) - cam64) <<< FRAC_BITS;
    q_raw  = r_neg ? (-div_quo - 64'sd1) : div_quo;
    if (q_raw < -64'sd1) begin
      q_clamp = -64'sd1;
    end else if (q_raw > DIMS64[k_q]) begin
      q_clamp = DIMS64[k_q];
    end else begin
      q_clamp = q_raw;
    end
    idx_up = (IDX_W + 1)'(idx_q[k_q]) + (r_neg ? '0 : (IDX_W + 1)'(1));
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = n0;
    div_den   = ar_k;
    mul_start = 1'b0;
    unique case (state_q)
      ST_BND0: begin
        div_start = (r_k != '0);
        div_num   = r_neg ? (-n0) : n0;
      end
      ST_BND1: begin
        div_start = 1'b1;
        div_num   = r_neg ? (-n1) : n1;
      end
      ST_ENT: begin
        if (r_k == '0) begin
          div_start = 1'b1;
          div_num   = cam64;
          div_den   = srs_pkg::DEN_W'(sp_k);
        end else begin
          mul_start = 1'b1;
        end
      end
      ST_EDIV: begin
        div_start = 1'b1;
        div_num   = r_neg ? (-e_pos) : e_pos;
        div_den   = srs_pkg::DEN_W'(sp_k);
      end
      ST_NXT: begin
        div_start = 1'b1;
        div_num   = r_neg ? (-n_nxt) : n_nxt;
      end
      ST_DU: begin
        div_start = 1'b1;
        div_num   = sp64 <<< FRAC_BITS;
      end
      default: ;
    endcase
  end

  // ---------------- walk selection ----------------
  logic                 found, inb_c;
  logic [1:0]           sel_c;
  logic signed [AW-1:0] nmin_c, end_c;
  logic signed [srs_pkg::VOX_W:0] vdiff;
  logic [PROD_W:0]      sum_c;

  always_comb begin
    found  = 1'b0;
    sel_c  = 2'd0;
    nmin_c = nxt_q[0];
    inb_c  = acc_q < ACC_SAT;
    // earliest plane crossing; ties go to the lower axis
    for (int k = 0; k < 3; k++) begin
      if (r_q[k] != '0 && (!found || nxt_q[k] < nmin_c)) begin
        found  = 1'b1;
        sel_c  = 2'(k);
        nmin_c = nxt_q[k];
      end
      inb_c = inb_c && (idx_q[k] >= 0) && (idx_q[k] < DIMS_I[k]);
    end
    addr_w = 32'(idx_q[0]) + 32'(idx_q[1]) * 32'(DIM_X) + 32'(idx_q[2]) * 32'(DIM_X * DIM_Y);
    mem_re = (state_q == ST_WALK);
    end_c  = (nmin_q < amax_q) ? nmin_q : amax_q;
    if (end_c < ac_q) begin
      end_c = ac_q;
    end
    vdiff = (srs_pkg::VOX_W + 1)'($signed(mem_rdata)) - (srs_pkg::VOX_W + 1)'(thr_q);
    sum_c = (PROD_W + 1)'(acc_q) + (PROD_W + 1)'(prod_q);
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      k_q      <= '0;
      amin_q   <= '0;
      amax_q   <= '0;
      a0_q     <= '0;
      ac_q     <= '0;
      end_q    <= '0;
      nmin_q   <= '0;
      delta_q  <= '0;
      pl_q     <= '0;
      any_q    <= 1'b0;
      inb_q    <= 1'b0;
      use_q    <= 1'b0;
      big_q    <= 1'b0;
      sel_q    <= '0;
      d_q      <= '0;
      prod_q   <= '0;
      acc_q    <= '0;
      step_q   <= '0;
      mvalid_q <= 1'b0;
      mdata_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        r_q[i]   <= '0;
        nxt_q[i] <= '0;
        du_q[i]  <= '0;
        idx_q[i] <= '0;
      end
    end else begin
      // drop the pixel once taken, unless a new one replaces it this cycle
      if (mvalid_q && m_axis_tready && state_q != ST_FIN) begin
        mvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser == srs_pkg::OP_RAY) begin
            for (int i = 0; i < 3; i++) begin
              r_q[i] <= srs_pkg::R_W'($signed(s_axis_tdata[34 + 32*i +: 32]))
                        - srs_pkg::R_W'(cam_q[i]);
            end
            k_q     <= '0;
            amin_q  <= -srs_pkg::ALPHA_BIG;
            amax_q  <= srs_pkg::ALPHA_BIG;
            any_q   <= 1'b0;
            state_q <= ST_BND0;
          end
        end
        ST_BND0: begin
          if (r_k != '0) begin
            ret_q   <= ST_BND1;
            state_q <= ST_DWAIT;
          end else if (k_q == 2'd2) begin
            state_q <= ST_CHECK;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_BND1: begin
          a0_q    <= div_quo;
          ret_q   <= ST_BNDUP;
          state_q <= ST_DWAIT;
        end
        ST_BNDUP: begin
          if (a0_q < div_quo) begin
            if (a0_q > amin_q) amin_q <= a0_q;
            if (div_quo < amax_q) amax_q <= div_quo;
          end else begin
            if (div_quo > amin_q) amin_q <= div_quo;
            if (a0_q < amax_q) amax_q <= a0_q;
          end
          any_q <= 1'b1;
          if (k_q == 2'd2) begin
            state_q <= ST_CHECK;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_BND0;
          end
        end
        ST_CHECK: begin
          acc_q <= '0;
          k_q   <= '0;
          // miss or degenerate ray: report zero
          if (!any_q || amin_q >= amax_q) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_ENT;
          end
        end
        ST_ENT: begin
          if (r_k == '0) begin
            ret_q   <= ST_IDX;
            state_q <= ST_DWAIT;
          end else begin
            state_q <= ST_MWAIT;
          end
        end
        ST_MWAIT: begin
          if (mul_done) state_q <= ST_EDIV;
        end
        ST_EDIV: begin
          ret_q   <= ST_IDX;
          state_q <= ST_DWAIT;
        end
        ST_IDX: begin
          idx_q[k_q] <= IDX_W'(q_clamp);
          if (r_k != '0) begin
            state_q <= ST_PL;
          end else if (k_q == 2'd2) begin
            ac_q    <= amin_q;
            step_q  <= '0;
            state_q <= ST_WALK;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_ENT;
          end
        end
        ST_PL: begin
          pl_q    <= PL_W'(idx_up) * PL_W'($signed({1'b0, sp_k}));
          state_q <= ST_NXT;
        end
        ST_NXT: begin
          ret_q   <= ST_DU;
          state_q <= ST_DWAIT;
        end
        ST_DU: begin
          nxt_q[k_q] <= div_quo;
          ret_q      <= ST_DUWR;
          state_q    <= ST_DWAIT;
        end
        ST_DUWR: begin
          du_q[k_q] <= (div_quo < 64'sd1) ? 64'sd1 : div_quo;
          if (k_q == 2'd2) begin
            ac_q    <= amin_q;
            step_q  <= '0;
            state_q <= ST_WALK;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_ENT;
          end
        end
        ST_DWAIT: begin
          if (div_done) state_q <= ret_q;
        end
        ST_WALK: begin
          if (step_q == STEP_W'(MAX_STEPS) || ac_q >= amax_q) begin
            state_q <= ST_FIN;
          end else begin
            sel_q   <= sel_c;
            nmin_q  <= nmin_c;
            inb_q   <= inb_c;
            state_q <= ST_END;
          end
        end
        ST_END: begin
          end_q   <= end_c;
          state_q <= ST_DLT;
        end
        ST_DLT: begin
          delta_q <= end_q - ac_q;
          use_q   <= inb_q && (vdiff > 0);
          d_q     <= vdiff[srs_pkg::DIFF_W-1:0];
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= PROD_W'(delta_q[ACC_W-1:0]) * PROD_W'(d_q);
          big_q   <= (delta_q[AW-1:ACC_W] != '0);
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (use_q) begin
            if (big_q || sum_c > (PROD_W + 1)'(ACC_SAT)) begin
              acc_q <= ACC_SAT;
            end else begin
              acc_q <= sum_c[ACC_W-1:0];
            end
          end
          ac_q <= end_q;
          // advance to the next voxel along the crossed axis
          idx_q[sel_q] <= r_q[sel_q][srs_pkg::R_W-1] ? (idx_q[sel_q] - IDX_W'(1))
                                                      : (idx_q[sel_q] + IDX_W'(1));
          nxt_q[sel_q] <= nxt_q[sel_q] + du_q[sel_q];
          step_q       <= step_q + STEP_W'(1);
          state_q      <= ST_WALK;
        end
        ST_FIN: begin
          if (!mvalid_q || m_axis_tready) begin
            mvalid_q <= 1'b1;
            mdata_q  <= acc_q[ACC_W-1] ? srs_pkg::PIX_MAX : acc_q[ACC_W-1:FRAC_BITS];
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------- checks ----------------
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= ACC_SAT)
    else $error("ray accumulator above saturation level");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(MAX_STEPS))
    else $error("segment count above limit");

  a_ray_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == srs_pkg::OP_RAY) |=> !s_axis_tready)
    else $error("input ready right after a ray word");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DWAIT) |-> !div_start && !mul_start)
    else $error("shared unit restarted while busy");

endmodule

// ===== design/srs_div.sv =====
// Bit-serial floor divider: signed 64-bit numerator by a positive 32-bit divisor.
// One quotient bit per cycle; uses srs_pkg widths.
`timescale 1ns / 1ps
module srs_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [srs_pkg::ALPHA_W-1:0]  num_i,
  input  logic        [srs_pkg::DEN_W-1:0]    den_i,
  output logic                                done_o,
  output logic signed [srs_pkg::ALPHA_W-1:0]  quo_o
);

  localparam int CNT_W = $clog2(srs_pkg::ALPHA_W + 1);

  logic                          run_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [srs_pkg::ALPHA_W-1:0]   mag_q;
  logic [srs_pkg::DEN_W-1:0]     rem_q;
  logic [srs_pkg::DEN_W-1:0]     den_q;
  logic                          neg_q;
  logic [srs_pkg::DEN_W:0]       rem_sh;
  logic                          qbit;
  logic [srs_pkg::DEN_W:0]       rem_sub;

  always_comb begin
    rem_sh  = {rem_q, mag_q[srs_pkg::ALPHA_W-1]};
    qbit    = rem_sh >= {1'b0, den_q};
    rem_sub = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      mag_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
      done_o <= 1'b0;
      quo_o  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(srs_pkg::ALPHA_W);
        neg_q <= num_i[srs_pkg::ALPHA_W-1];
        mag_q <= num_i[srs_pkg::ALPHA_W-1] ? (-num_i) : num_i;
        rem_q <= '0;
        den_q <= den_i;
      end else if (run_q) begin
        if (cnt_q != '0) begin
          mag_q <= {mag_q[srs_pkg::ALPHA_W-2:0], qbit};
          rem_q <= rem_sub[srs_pkg::DEN_W-1:0];
          cnt_q <= cnt_q - CNT_W'(1);
        end else begin
          // fold the sign back, rounding toward minus infinity
          run_q  <= 1'b0;
          done_o <= 1'b1;
          if (neg_q) begin
            quo_o <= (-$signed(mag_q)) - ((rem_q != '0) ? 64'sd1 : 64'sd0);
          end else begin
            quo_o <= $signed(mag_q);
          end
        end
      end
    end
  end

endmodule

// ===== design/srs_mul.sv =====
// Bit-serial saturating multiplier: 64-bit alpha times 33-bit ray direction.
// Magnitude clips at 2^62 as soon as a partial sum passes it; uses srs_pkg widths.
`timescale 1ns / 1ps
module srs_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [srs_pkg::ALPHA_W-1:0]  a_i,
  input  logic signed [srs_pkg::R_W-1:0]      b_i,
  output logic                                done_o,
  output logic signed [srs_pkg::ALPHA_W-1:0]  p_o
);

  localparam int UB_W  = srs_pkg::R_W - 1;
  localparam int CNT_W = $clog2(UB_W + 1);
  localparam int P_W   = srs_pkg::ALPHA_W - 1;
  localparam int S_W   = srs_pkg::ALPHA_W + 1;

  logic                         run_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [srs_pkg::ALPHA_W-1:0]  ua_q;
  logic [UB_W-1:0]              ub_q;
  logic [P_W-1:0]               p_q;
  logic                         sat_q;
  logic                         neg_q;
  logic [srs_pkg::R_W-1:0]      b_abs;
  logic [S_W-1:0]               sum;
  logic [srs_pkg::ALPHA_W-1:0]  mag;

  always_comb begin
    b_abs = b_i[srs_pkg::R_W-1] ? (-b_i) : b_i;
    sum   = {1'b0, p_q, 1'b0} + (ub_q[UB_W-1] ? {1'b0, ua_q} : '0);
    mag   = sat_q ? srs_pkg::ALPHA_BIG : {1'b0, p_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      ua_q   <= '0;
      ub_q   <= '0;
      p_q    <= '0;
      sat_q  <= 1'b0;
      neg_q  <= 1'b0;
      done_o <= 1'b0;
      p_o    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(UB_W);
        ua_q  <= a_i[srs_pkg::ALPHA_W-1] ? (-a_i) : a_i;
        ub_q  <= b_abs[UB_W-1:0];
        p_q   <= '0;
        sat_q <= 1'b0;
        neg_q <= a_i[srs_pkg::ALPHA_W-1] ^ b_i[srs_pkg::R_W-1];
      end else if (run_q) begin
        if (cnt_q != '0) begin
          // most significant multiplier bit first; clip is sticky
          if (!sat_q) begin
            if (sum > S_W'(srs_pkg::ALPHA_BIG)) begin
              sat_q <= 1'b1;
            end else begin
              p_q <= sum[P_W-1:0];
            end
          end
          ub_q  <= {ub_q[UB_W-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
        end else begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
          p_o    <= neg_q ? (-$signed(mag)) : $signed(mag);
        end
      end
    end
  end

endmodule

// ===== design/srs_mem.sv =====
// Volume memory: one write port, one registered read port, 16-bit voxels.
// Contents are undefined until written; uses srs_pkg widths.
`timescale 1ns / 1ps
module srs_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [srs_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [srs_pkg::VOX_W-1:0]    wdata_i,
  input  logic                         re_i,
  input  logic [srs_pkg::ADDR_W-1:0]   raddr_i,
  output logic [srs_pkg::VOX_W-1:0]    rdata_o
);

  logic [srs_pkg::VOX_W-1:0] mem [srs_pkg::MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
